FILE: hw/rtl/est_pkg.sv
package est_pkg;

   localparam int POS_BITS    = 16;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_F  = 8'h66;

   // keyword match progress: "true" runs 1..4, "false" runs 5..9
   localparam logic [3:0] KW_NONE       = 4'd0;
   localparam logic [3:0] KW_TRUE_START = 4'd1;
   localparam logic [3:0] KW_TRUE_LAST  = 4'd3;
   localparam logic [3:0] KW_TRUE_DONE  = 4'd4;
   localparam logic [3:0] KW_FALSE_START = 4'd5;
   localparam logic [3:0] KW_FALSE_LAST  = 4'd8;
   localparam logic [3:0] KW_FALSE_DONE  = 4'd9;

   typedef enum logic [4:0] {
      KIND_PLUS   = 5'd0,
      KIND_MINUS  = 5'd1,
      KIND_TIMES  = 5'd2,
      KIND_POWER  = 5'd3,
      KIND_DIVIDE = 5'd4,
      KIND_ROOT   = 5'd5,
      KIND_LBRACE = 5'd6,
      KIND_RBRACE = 5'd7,
      KIND_LPAREN = 5'd8,
      KIND_RPAREN = 5'd9,
      KIND_EQUAL  = 5'd10,
      KIND_ASSIGN = 5'd11,
      KIND_NUMBER = 5'd12,
      KIND_TRUE   = 5'd13,
      KIND_FALSE  = 5'd14,
      KIND_IDENT  = 5'd15,
      KIND_ERROR  = 5'd16
   } kind_type;

   typedef enum logic [5:0] {
      MODE_IDLE  = 6'b000001,
      MODE_NUM   = 6'b000010,
      MODE_IDENT = 6'b000100,
      MODE_STAR  = 6'b001000,
      MODE_SLASH = 6'b010000,
      MODE_EQ    = 6'b100000
   } mode_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [7:0]  bad;
      logic        last;
   } tok_type;

   typedef struct packed {
      logic [1:0] n;
      tok_type    t0;
      tok_type    t1;
   } tokpair_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic [7:0] kw_char(input logic [3:0] p);
      logic [7:0] r;
      case (p)
         4'd1: r = 8'h74;
         4'd2: r = 8'h72;
         4'd3: r = 8'h75;
         4'd4: r = 8'h65;
         4'd5: r = 8'h66;
         4'd6: r = 8'h61;
         4'd7: r = 8'h6C;
         4'd8: r = 8'h73;
         4'd9: r = 8'h65;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] kw_next(input logic [3:0] p, input logic [7:0] c);
      logic [3:0] r;
      r = KW_NONE;
      if (((p >= KW_TRUE_START) && (p <= KW_TRUE_LAST)) ||
          ((p >= KW_FALSE_START) && (p <= KW_FALSE_LAST))) begin
         if (kw_char(p + 4'd1) == c) begin
            r = p + 4'd1;
         end
      end
      return r;
   endfunction

   function automatic kind_type word_kind(input logic [3:0] p);
      kind_type k;
      if (p == KW_TRUE_DONE) begin
         k = KIND_TRUE;
      end else if (p == KW_FALSE_DONE) begin
         k = KIND_FALSE;
      end else begin
         k = KIND_IDENT;
      end
      return k;
   endfunction

   function automatic logic [15:0] cap_word(input logic [POS_BITS:0] v);
      logic [15:0] r;
      if (v > (POS_BITS + 1)'(17'h0FFFF)) begin
         r = 16'hFFFF;
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/est_front.sv
module est_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_byte,
   input  logic                end_of_text,
   output est_pkg::tokpair_type wr
);

   localparam logic [est_pkg::POS_BITS-1:0] POS_MAX = {est_pkg::POS_BITS{1'b1}};

   est_pkg::mode_type               mode_ff, mode_in;
   logic [3:0]                      kp_ff, kp_in;
   logic [est_pkg::POS_BITS-1:0]    pos_ff, pos_in;
   logic [est_pkg::POS_BITS-1:0]    ps_ff, ps_in;

   est_pkg::mode_type               mode1, mode2;
   logic [3:0]                      kp1, kp2;
   logic [est_pkg::POS_BITS-1:0]    ps2;
   logic                            consumed;
   logic                            va, vb, vc;
   est_pkg::tok_type                tok_a, tok_b, tok_c;
   logic [est_pkg::POS_BITS:0]      span_a, span_c;
   logic [7:0]                      want;
   est_pkg::kind_type               pair_kind, single_kind;
   logic [1:0]                      cnt;

   always_comb begin
      consumed = 1'b0;
      va       = 1'b0;
      tok_a    = '0;
      mode1    = mode_ff;
      kp1      = kp_ff;
      span_a   = {1'b0, pos_ff} - {1'b0, ps_ff};
      want     = est_pkg::CH_EQ;
      pair_kind   = est_pkg::KIND_EQUAL;
      single_kind = est_pkg::KIND_ASSIGN;
      if (mode_ff == est_pkg::MODE_STAR) begin
         want        = est_pkg::CH_STAR;
         pair_kind   = est_pkg::KIND_POWER;
         single_kind = est_pkg::KIND_TIMES;
      end else if (mode_ff == est_pkg::MODE_SLASH) begin
         want        = est_pkg::CH_SLASH;
         pair_kind   = est_pkg::KIND_ROOT;
         single_kind = est_pkg::KIND_DIVIDE;
      end
      tok_a.start = est_pkg::cap_word({1'b0, ps_ff});

      case (mode_ff)
         est_pkg::MODE_STAR, est_pkg::MODE_SLASH, est_pkg::MODE_EQ: begin
            va    = 1'b1;
            mode1 = est_pkg::MODE_IDLE;
            if (char_byte == want) begin
               tok_a.kind   = pair_kind;
               tok_a.length = 16'd2;
               consumed     = 1'b1;
            end else begin
               tok_a.kind   = single_kind;
               tok_a.length = 16'd1;
               kp1          = est_pkg::KW_NONE;
            end
         end
         est_pkg::MODE_NUM: begin
            if (est_pkg::is_digit(char_byte)) begin
               consumed = 1'b1;
            end else begin
               va           = 1'b1;
               tok_a.kind   = est_pkg::KIND_NUMBER;
               tok_a.length = est_pkg::cap_word(span_a);
               mode1        = est_pkg::MODE_IDLE;
               kp1          = est_pkg::KW_NONE;
            end
         end
         est_pkg::MODE_IDENT: begin
            if (est_pkg::is_alpha(char_byte) || est_pkg::is_digit(char_byte) ||
                (char_byte == est_pkg::CH_UNDER)) begin
               kp1      = est_pkg::kw_next(kp_ff, char_byte);
               consumed = 1'b1;
            end else begin
               va           = 1'b1;
               tok_a.kind   = est_pkg::word_kind(kp_ff);
               tok_a.length = est_pkg::cap_word(span_a);
               mode1        = est_pkg::MODE_IDLE;
               kp1          = est_pkg::KW_NONE;
            end
         end
         default: begin
            mode1 = est_pkg::MODE_IDLE;
         end
      endcase
   end

   // fresh scan of the byte when the pending token did not take it
   always_comb begin
      mode2 = mode1;
      kp2   = kp1;
      ps2   = ps_ff;
      vb    = 1'b0;
      tok_b = '0;
      tok_b.start  = est_pkg::cap_word({1'b0, pos_ff});
      tok_b.length = 16'd1;
      if (!consumed) begin
         mode2 = est_pkg::MODE_IDLE;
         case (char_byte)
            est_pkg::CH_SPACE: begin
            end
            est_pkg::CH_PLUS: begin
               vb = 1'b1;
               tok_b.kind = est_pkg::KIND_PLUS;
            end
            est_pkg::CH_MINUS: begin
               vb = 1'b1;
               tok_b.kind = est_pkg::KIND_MINUS;
            end
            est_pkg::CH_LBRACE: begin
               vb = 1'b1;
               tok_b.kind = est_pkg::KIND_LBRACE;
            end
            est_pkg::CH_RBRACE: begin
               vb = 1'b1;
               tok_b.kind = est_pkg::KIND_RBRACE;
            end
            est_pkg::CH_LPAREN: begin
               vb = 1'b1;
               tok_b.kind = est_pkg::KIND_LPAREN;
            end
            est_pkg::CH_RPAREN: begin
               vb = 1'b1;
               tok_b.kind = est_pkg::KIND_RPAREN;
            end
            est_pkg::CH_STAR: begin
               mode2 = est_pkg::MODE_STAR;
               ps2   = pos_ff;
            end
            est_pkg::CH_SLASH: begin
               mode2 = est_pkg::MODE_SLASH;
               ps2   = pos_ff;
            end
            est_pkg::CH_EQ: begin
               mode2 = est_pkg::MODE_EQ;
               ps2   = pos_ff;
            end
            default: begin
               if (est_pkg::is_digit(char_byte)) begin
                  mode2 = est_pkg::MODE_NUM;
                  ps2   = pos_ff;
               end else if (est_pkg::is_alpha(char_byte)) begin
                  mode2 = est_pkg::MODE_IDENT;
                  ps2   = pos_ff;
                  if (char_byte == est_pkg::CH_LOW_T) begin
                     kp2 = est_pkg::KW_TRUE_START;
                  end else if (char_byte == est_pkg::CH_LOW_F) begin
                     kp2 = est_pkg::KW_FALSE_START;
                  end else begin
                     kp2 = est_pkg::KW_NONE;
                  end
               end else begin
                  vb         = 1'b1;
                  tok_b.kind = est_pkg::KIND_ERROR;
                  tok_b.bad  = char_byte;
               end
            end
         endcase
      end
   end

   // final byte: flush whatever is still pending, including this byte
   always_comb begin
      vc     = 1'b0;
      tok_c  = '0;
      span_c = {1'b0, pos_ff} - {1'b0, ps2} + {{est_pkg::POS_BITS{1'b0}}, 1'b1};
      tok_c.start  = est_pkg::cap_word({1'b0, ps2});
      tok_c.length = 16'd1;
      if (end_of_text) begin
         case (mode2)
            est_pkg::MODE_STAR: begin
               vc = 1'b1;
               tok_c.kind = est_pkg::KIND_TIMES;
            end
            est_pkg::MODE_SLASH: begin
               vc = 1'b1;
               tok_c.kind = est_pkg::KIND_DIVIDE;
            end
            est_pkg::MODE_EQ: begin
               vc = 1'b1;
               tok_c.kind = est_pkg::KIND_ASSIGN;
            end
            est_pkg::MODE_NUM: begin
               vc = 1'b1;
               tok_c.kind   = est_pkg::KIND_NUMBER;
               tok_c.length = est_pkg::cap_word(span_c);
            end
            est_pkg::MODE_IDENT: begin
               vc = 1'b1;
               tok_c.kind   = est_pkg::word_kind(kp2);
               tok_c.length = est_pkg::cap_word(span_c);
            end
            default: begin
            end
         endcase
      end
   end

   // at most two of the three candidates fire for one byte
   always_comb begin
      cnt   = {1'b0, va} + {1'b0, vb} + {1'b0, vc};
      wr    = '0;
      wr.n  = accept ? cnt : 2'd0;
      if (va) begin
         wr.t0 = tok_a;
         wr.t1 = vb ? tok_b : tok_c;
      end else if (vb) begin
         wr.t0 = tok_b;
         wr.t1 = tok_c;
      end else begin
         wr.t0 = tok_c;
         wr.t1 = tok_c;
      end
      wr.t0.last = (cnt == 2'd1);
      wr.t1.last = 1'b1;
   end

   always_comb begin
      if (end_of_text) begin
         mode_in = est_pkg::MODE_IDLE;
         kp_in   = est_pkg::KW_NONE;
         pos_in  = '0;
         ps_in   = '0;
      end else begin
         mode_in = mode2;
         kp_in   = kp2;
         pos_in  = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
         ps_in   = ps2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= est_pkg::MODE_IDLE;
         kp_ff   <= est_pkg::KW_NONE;
         pos_ff  <= '0;
         ps_ff   <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         kp_ff   <= kp_in;
         pos_ff  <= pos_in;
         ps_ff   <= ps_in;
      end
   end

endmodule

FILE: hw/rtl/est_tokq.sv
module est_tokq (
   input  logic                 clock,
   input  logic                 reset,
   input  est_pkg::tokpair_type wr,
   input  logic                 pop,
   output est_pkg::tok_type     head,
   output logic                 empty,
   output logic                 full
);

   est_pkg::tok_type                 data_ff [est_pkg::QUEUE_DEPTH];
   logic [est_pkg::QPTR_BITS-1:0]    wp_ff, wp_in, wp_second;
   logic [est_pkg::QPTR_BITS-1:0]    rp_ff, rp_in;
   logic [est_pkg::QCNT_BITS-1:0]    count_ff, count_in;
   logic                             pop_ok;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff > est_pkg::QCNT_BITS'(est_pkg::QUEUE_DEPTH - 2));
   assign head      = data_ff[rp_ff];
   assign pop_ok    = pop && !empty;
   assign wp_second = wp_ff + est_pkg::QPTR_BITS'(1);
   assign wp_in     = wp_ff + est_pkg::QPTR_BITS'(wr.n);
   assign rp_in     = rp_ff + est_pkg::QPTR_BITS'(pop_ok);
   assign count_in  = count_ff + est_pkg::QCNT_BITS'(wr.n) - est_pkg::QCNT_BITS'(pop_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.n != 2'd0) begin
         data_ff[wp_ff] <= wr.t0;
      end
      if (wr.n == 2'd2) begin
         data_ff[wp_second] <= wr.t1;
      end
   end

endmodule

FILE: hw/rtl/expression_token_scanner_top.sv
// Tokenizer for a small expression language. Bytes of the text arrive one
// word per cycle on the req_ side, with req_end_of_text set on the final
// byte; tokens leave in order on the rsp_ side, each with kind, start
// position, length, offending byte for error tokens and a flag on the last
// token a byte caused. A byte is taken every cycle that the eight-entry token
// queue has two free slots, so the scanner runs at one byte per cycle while
// the consumer pops at least as many tokens as are made; a token enters the
// queue as the byte that completes it is taken. The one-token-per-cycle
// pop port of the queue is what limits sustained throughput.
module expression_token_scanner_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_text,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic [7:0]  rsp_bad_char,
   output logic        rsp_run_last
);

   est_pkg::tokpair_type wr;
   est_pkg::tok_type     head;
   logic                 accept;

   assign accept = req_push && !req_full;

   est_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_byte   (req_char_byte),
      .end_of_text (req_end_of_text),
      .wr          (wr)
   );

   est_tokq u_tokq (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .pop   (rsp_pop),
      .head  (head),
      .empty (rsp_empty),
      .full  (req_full)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.length;
   assign rsp_bad_char     = head.bad;
   assign rsp_run_last     = head.last;

endmodule

FILE: hw/rtl/est_checker.sv
module est_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic [4:0]  rsp_token_kind,
   input logic [15:0] rsp_token_length,
   input logic [7:0]  rsp_bad_char
);

   a_reset_empty : assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("queue not empty after reset");

   a_reset_room : assert property (@(posedge clock) reset |=> !req_full)
      else $error("input blocked after reset");

   a_kind_range : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_token_kind <= 5'(est_pkg::KIND_ERROR)))
      else $error("token kind out of range");

   a_length_nonzero : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_token_length != 16'd0))
      else $error("zero token length");

   a_bad_only_error : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_token_kind != 5'(est_pkg::KIND_ERROR))) |-> (rsp_bad_char == 8'd0))
      else $error("bad byte on non-error token");

endmodule

bind expression_token_scanner_top est_checker u_est_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_token_kind   (rsp_token_kind),
   .rsp_token_length (rsp_token_length),
   .rsp_bad_char     (rsp_bad_char)
);

FILE: dv/expression_token_scanner_top_tb.sv
module expression_token_scanner_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import est_pkg::*;

   typedef struct {
      logic [7:0] ch;
      logic       eot;
   } char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_char_byte = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [4:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic [7:0]  rsp_bad_char;
   logic        rsp_run_last;

   char_type    char_q[$];
   tok_type     token_q[$];
   tok_type     got_tok;
   int          errors = 0;
   int          idle_pct = 31;

   // scanner state mirror
   mode_type    sc_mode = MODE_IDLE;
   logic [3:0]  sc_kw = KW_NONE;
   logic [15:0] sc_pos = 16'd0;
   logic [15:0] sc_pend = 16'd0;

   expression_token_scanner_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_char_byte    (req_char_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_bad_char     (rsp_bad_char),
      .rsp_run_last     (rsp_run_last)
   );

   always #5 clock = ~clock;

   function automatic logic digit_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic letter_ch(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   // character expected at keyword progress p
   function automatic logic [7:0] spell_at(logic [3:0] p);
      logic [7:0] r;
      case (p)
         4'd2: r = "r";
         4'd3: r = "u";
         4'd4: r = "e";
         4'd6: r = "a";
         4'd7: r = "l";
         4'd8: r = "s";
         4'd9: r = "e";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic void push_token(kind_type k, logic [15:0] s, logic [16:0] len,
                                      logic [7:0] bad);
      tok_type t;
      t.kind = k;
      t.start = s;
      t.length = (len > 17'h0FFFF) ? 16'hFFFF : len[15:0];
      t.bad = bad;
      t.last = 1'b0;
      token_q.insert(token_q.size(), t);
   endfunction

   function automatic void flush_pending(logic [15:0] pos, logic extra);
      logic [16:0] span;
      span = ((pos >= sc_pend) ? ({1'b0, pos} - {1'b0, sc_pend}) : 17'd0) + {16'd0, extra};
      case (sc_mode)
         MODE_STAR:  push_token(KIND_TIMES, sc_pend, 17'd1, 8'h00);
         MODE_SLASH: push_token(KIND_DIVIDE, sc_pend, 17'd1, 8'h00);
         MODE_EQ:    push_token(KIND_ASSIGN, sc_pend, 17'd1, 8'h00);
         MODE_NUM:   push_token(KIND_NUMBER, sc_pend, span, 8'h00);
         MODE_IDENT: begin
            if (sc_kw == KW_TRUE_DONE) begin
               push_token(KIND_TRUE, sc_pend, span, 8'h00);
            end else if (sc_kw == KW_FALSE_DONE) begin
               push_token(KIND_FALSE, sc_pend, span, 8'h00);
            end else begin
               push_token(KIND_IDENT, sc_pend, span, 8'h00);
            end
         end
         default: ;
      endcase
      sc_mode = MODE_IDLE;
      sc_kw = KW_NONE;
   endfunction

   function automatic void start_token(logic [7:0] c, logic [15:0] pos);
      sc_mode = MODE_IDLE;
      case (c)
         CH_SPACE:  ;
         CH_PLUS:   push_token(KIND_PLUS, pos, 17'd1, 8'h00);
         CH_MINUS:  push_token(KIND_MINUS, pos, 17'd1, 8'h00);
         CH_LBRACE: push_token(KIND_LBRACE, pos, 17'd1, 8'h00);
         CH_RBRACE: push_token(KIND_RBRACE, pos, 17'd1, 8'h00);
         CH_LPAREN: push_token(KIND_LPAREN, pos, 17'd1, 8'h00);
         CH_RPAREN: push_token(KIND_RPAREN, pos, 17'd1, 8'h00);
         CH_STAR: begin
            sc_mode = MODE_STAR;
            sc_pend = pos;
         end
         CH_SLASH: begin
            sc_mode = MODE_SLASH;
            sc_pend = pos;
         end
         CH_EQ: begin
            sc_mode = MODE_EQ;
            sc_pend = pos;
         end
         default: begin
            if (digit_ch(c)) begin
               sc_mode = MODE_NUM;
               sc_pend = pos;
            end else if (letter_ch(c)) begin
               sc_mode = MODE_IDENT;
               sc_pend = pos;
               if (c == CH_LOW_T) begin
                  sc_kw = KW_TRUE_START;
               end else if (c == CH_LOW_F) begin
                  sc_kw = KW_FALSE_START;
               end else begin
                  sc_kw = KW_NONE;
               end
            end else begin
               push_token(KIND_ERROR, pos, 17'd1, c);
            end
         end
      endcase
   endfunction

   // expected tokens for one accepted word
   function automatic void scan_char(logic [7:0] c, logic eot);
      logic [15:0] pos;
      int          n0;
      logic        taken;
      logic [7:0]  pair_ch;
      kind_type    pair_kind;
      pos = sc_pos;
      n0 = token_q.size();
      taken = 1'b0;
      case (sc_mode)
         MODE_STAR, MODE_SLASH, MODE_EQ: begin
            if (sc_mode == MODE_STAR) begin
               pair_ch = CH_STAR;
               pair_kind = KIND_POWER;
            end else if (sc_mode == MODE_SLASH) begin
               pair_ch = CH_SLASH;
               pair_kind = KIND_ROOT;
            end else begin
               pair_ch = CH_EQ;
               pair_kind = KIND_EQUAL;
            end
            if (c == pair_ch) begin
               push_token(pair_kind, sc_pend, 17'd2, 8'h00);
               sc_mode = MODE_IDLE;
               taken = 1'b1;
            end else begin
               flush_pending(pos, 1'b0);
            end
         end
         MODE_NUM: begin
            if (digit_ch(c)) begin
               taken = 1'b1;
            end else begin
               flush_pending(pos, 1'b0);
            end
         end
         MODE_IDENT: begin
            if (letter_ch(c) || digit_ch(c) || c == CH_UNDER) begin
               if ((sc_kw >= KW_TRUE_START && sc_kw <= KW_TRUE_LAST) ||
                   (sc_kw >= KW_FALSE_START && sc_kw <= KW_FALSE_LAST)) begin
                  sc_kw = (spell_at(sc_kw + 4'd1) == c) ? sc_kw + 4'd1 : KW_NONE;
               end else begin
                  sc_kw = KW_NONE;
               end
               taken = 1'b1;
            end else begin
               flush_pending(pos, 1'b0);
            end
         end
         default: sc_mode = MODE_IDLE;
      endcase
      if (!taken) begin
         start_token(c, pos);
      end
      if (eot) begin
         flush_pending(pos, 1'b1);
         sc_pos = 16'd0;
         sc_pend = 16'd0;
      end else begin
         sc_pos = (pos == 16'hFFFF) ? pos : pos + 16'd1;
      end
      if (token_q.size() > n0) begin
         token_q[token_q.size() - 1].last = 1'b1;
      end
   endfunction

   function automatic void check_field(string what, logic [15:0] want_v, logic [15:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
         errors++;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            scan_char(req_char_byte, req_end_of_text);
            void'(char_q.pop_front());
         end
         if (char_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_push <= 1'b1;
            req_char_byte <= char_q[0].ch;
            req_end_of_text <= char_q[0].eot;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (token_q.size() == 0) begin
               $display("%0t: unexpected token: expected none, actual kind %0d start %0d",
                        $time, rsp_token_kind, rsp_token_start);
               errors++;
            end else begin
               got_tok = token_q.pop_front();
               check_field("token_kind", 16'(got_tok.kind), 16'(rsp_token_kind));
               check_field("token_start", got_tok.start, rsp_token_start);
               check_field("token_length", got_tok.length, rsp_token_length);
               check_field("bad_char", 16'(got_tok.bad), 16'(rsp_bad_char));
               check_field("run_last", 16'(got_tok.last), 16'(rsp_run_last));
            end
         end
         rsp_pop <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic put_ch(logic [7:0] c, logic eot);
      char_type w;
      w.ch = c;
      w.eot = eot;
      char_q.insert(char_q.size(), w);
   endtask

   // text of s, end marked on its final character
   task automatic put_text(string s, logic eot);
      for (int i = 0; i < s.len(); i++) begin
         put_ch(s[i], eot && (i == s.len() - 1));
      end
   endtask

   function automatic logic [7:0] rand_letter();
      logic [7:0] base;
      base = ($urandom_range(1) == 0) ? "a" : "A";
      return base + 8'($urandom_range(25));
   endfunction

   task automatic put_piece();
      int r;
      int n;
      int k;
      r = $urandom_range(99);
      if (r < 12) begin
         put_ch(8'($urandom_range(255)), 1'b0);
      end else if (r < 22) begin
         put_ch(CH_SPACE, 1'b0);
      end else if (r < 40) begin
         n = $urandom_range(4, 1);
         for (int i = 0; i < n; i++) begin
            put_ch(8'h30 + 8'($urandom_range(9)), 1'b0);
         end
      end else if (r < 58) begin
         put_ch(rand_letter(), 1'b0);
         n = $urandom_range(5);
         for (int i = 0; i < n; i++) begin
            k = $urandom_range(3);
            if (k == 0) begin
               put_ch(8'h30 + 8'($urandom_range(9)), 1'b0);
            end else if (k == 1) begin
               put_ch(CH_UNDER, 1'b0);
            end else begin
               put_ch(rand_letter(), 1'b0);
            end
         end
      end else if (r < 70) begin
         case ($urandom_range(7))
            0: put_text("true", 1'b0);
            1: put_text("false", 1'b0);
            2: put_text("tru", 1'b0);
            3: put_text("fals", 1'b0);
            4: put_text("truex", 1'b0);
            5: put_text("false_", 1'b0);
            6: put_text("trUe", 1'b0);
            default: put_text("f", 1'b0);
         endcase
      end else if (r < 87) begin
         case ($urandom_range(7))
            0: put_text("**", 1'b0);
            1: put_text("//", 1'b0);
            2: put_text("==", 1'b0);
            3: put_ch(CH_STAR, 1'b0);
            4: put_ch(CH_SLASH, 1'b0);
            5: put_ch(CH_EQ, 1'b0);
            6: put_ch(CH_PLUS, 1'b0);
            default: put_ch(CH_MINUS, 1'b0);
         endcase
      end else begin
         case ($urandom_range(3))
            0: put_ch(CH_LBRACE, 1'b0);
            1: put_ch(CH_RBRACE, 1'b0);
            2: put_ch(CH_LPAREN, 1'b0);
            default: put_ch(CH_RPAREN, 1'b0);
         endcase
      end
   endtask

   task automatic put_random_text();
      int n;
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++) begin
         put_piece();
      end
      char_q[char_q.size() - 1].eot = 1'b1;
   endtask

   initial begin
      int added;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // pairs, pending single operators, final flush of a pending '='
      put_text("**//==*-/+=", 1'b1);
      // number ended by a letter, keyword flushed by the final character
      put_text("7x false", 1'b1);
      put_text("true{}()", 1'b1);
      // error bytes at both extremes, final space flushing an identifier
      put_ch(8'h00, 1'b0);
      put_ch(8'hFF, 1'b0);
      put_text("a ", 1'b1);
      wait (char_q.size() == 0);

      for (int chunk = 0; chunk < 3; chunk++) begin
         idle_pct = (chunk == 1) ? 0 : 31;
         added = 0;
         while (added < 160) begin
            added -= char_q.size();
            put_random_text();
            added += char_q.size();
         end
         wait (char_q.size() == 0);
      end

      wait (token_q.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0 && token_q.size() == 0) begin
         $display("expression_token_scanner_top_tb passed");
      end else begin
         $display("expression_token_scanner_top_tb failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("expression_token_scanner_top_tb failed");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/est_pkg.sv
hw/rtl/est_front.sv
hw/rtl/est_tokq.sv
hw/rtl/expression_token_scanner_top.sv
hw/rtl/est_checker.sv
dv/expression_token_scanner_top_tb.sv
